### hw/rtl/icht_pkg.sv
// Package for the indexed configuration history table.
// Holds sizes, command and status codes, payload structs and ring helpers.
// No dependencies.
package icht_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int LINES  = 2 * DEPTH;
    localparam int LINE_W = $clog2(LINES);
    localparam int IDX_W  = 63;
    localparam int PAY_W  = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [LINE_W-1:0] line_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [PAY_W-1:0]  pay_t;

    localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DROP_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_SNAP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLOOR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_LAST  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_ORDER      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STAT_W-1:0] ST_OLD_SNAP   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BELOW_SNAP = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             which_list;
        idx_t             log_index;
        pay_t             payload_handle;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        idx_t              result_index;
        pay_t              result_payload;
        logic              from_snapshot;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LAST,
        ST_FRONT,
        ST_BACK,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Store line of ring position pos in list l; head and pos are both below DEPTH.
    function automatic line_t line_of(logic l, ptr_t head, cnt_t pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return LINE_W'(sum) + (l ? LINE_W'(DEPTH) : LINE_W'(0));
    endfunction

    function automatic ptr_t head_inc(ptr_t h);
        return (h == PTR_W'(DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

endpackage

### hw/rtl/indexed_config_history_table_top.sv
// Top level of the indexed configuration history table.
// Depends on icht_pkg; holds the entry stores and the command sequencer.
//
// Usage: one command enters on the s_ channel (valid/ready), one result leaves
// on the m_ channel per command. Two ring lists (voter, learner) of DEPTH
// entries each live in one synchronous store pair of 2*DEPTH lines with a
// registered read; the snapshot entries and ring pointers sit in flip-flops.
// Commands run one at a time through a read-compare-write sequencer.
// Append and read_last first read the last stored entry of a non-empty list.
// floor_lookup compares stored entries, one per cycle: the entries not above
//   the key plus the first entry above it, at most the list length.
// drop_front / drop_back compare one stored entry per cycle: the entries
//   dropped in both lists plus one per list that still holds entries afterwards.
// The result sits in an output register; the next command is taken while it
// waits, but a finished command holds in its final state until the register
// frees up, so a stalled receiver backs up into s_ready.
// Reset (aresetn low at a clock edge) empties both lists, zeroes the
// snapshots and drops any pending result. The stores need no clearing.
module indexed_config_history_table_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  icht_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output icht_pkg::out_t  m_data
);

    icht_pkg::idx_t idx_mem [icht_pkg::LINES];
    icht_pkg::pay_t pay_mem [icht_pkg::LINES];
    icht_pkg::idx_t rd_idx_reg;
    icht_pkg::pay_t rd_pay_reg;

    icht_pkg::line_t rd_addr;
    logic            wr_en;
    icht_pkg::line_t wr_addr;

    icht_pkg::state_t state_reg, state_next;
    logic [icht_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic           list_reg, list_next;
    logic           cur_reg, cur_next;
    icht_pkg::idx_t key_reg, key_next;
    icht_pkg::pay_t pay_reg, pay_next;
    icht_pkg::ptr_t head_reg [2];
    icht_pkg::ptr_t head_next [2];
    icht_pkg::cnt_t count_reg [2];
    icht_pkg::cnt_t count_next [2];
    icht_pkg::idx_t snap_idx_reg [2];
    icht_pkg::idx_t snap_idx_next [2];
    icht_pkg::pay_t snap_pay_reg [2];
    icht_pkg::pay_t snap_pay_next [2];
    icht_pkg::cnt_t pos_reg, pos_next;
    icht_pkg::idx_t best_idx_reg, best_idx_next;
    icht_pkg::pay_t best_pay_reg, best_pay_next;
    icht_pkg::out_t res_reg, res_next;
    icht_pkg::out_t m_data_reg, m_data_next;
    logic           m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == icht_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Entry stores: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            idx_mem[wr_addr] <= key_reg;
            pay_mem[wr_addr] <= pay_reg;
        end
        rd_idx_reg <= idx_mem[rd_addr];
        rd_pay_reg <= pay_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= icht_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            head_reg[0]   <= '0;
            head_reg[1]   <= '0;
            count_reg[0]  <= '0;
            count_reg[1]  <= '0;
            snap_idx_reg[0] <= '0;
            snap_idx_reg[1] <= '0;
            snap_pay_reg[0] <= '0;
            snap_pay_reg[1] <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            snap_idx_reg  <= snap_idx_next;
            snap_pay_reg  <= snap_pay_next;
        end
        cmd_reg      <= cmd_next;
        list_reg     <= list_next;
        cur_reg      <= cur_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        pos_reg      <= pos_next;
        best_idx_reg <= best_idx_next;
        best_pay_reg <= best_pay_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        icht_pkg::cnt_t n;
        icht_pkg::ptr_t hd;
        icht_pkg::cnt_t cnt;
        icht_pkg::cnt_t cnt2;
        icht_pkg::cnt_t p1;
        icht_pkg::ptr_t h2;
        logic           adv;

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        list_next     = list_reg;
        cur_next      = cur_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        snap_idx_next = snap_idx_reg;
        snap_pay_next = snap_pay_reg;
        pos_next      = pos_reg;
        best_idx_next = best_idx_reg;
        best_pay_next = best_pay_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        adv           = 1'b0;
        h2            = '0;
        cnt2          = '0;
        p1            = '0;

        n   = count_reg[list_reg];
        hd  = head_reg[list_reg];
        cnt = count_reg[cur_reg];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            icht_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data.command;
                    list_next  = s_data.which_list;
                    key_next   = s_data.log_index;
                    pay_next   = s_data.payload_handle;
                    state_next = icht_pkg::ST_EXEC;
                end
            end
            icht_pkg::ST_EXEC: begin
                res_next   = '0;
                state_next = icht_pkg::ST_DONE;
                case (cmd_reg)
                    icht_pkg::CMD_APPEND: begin
                        if (n == '0) begin
                            wr_en = 1'b1;
                            wr_addr = icht_pkg::line_of(list_reg, hd, '0);
                            count_next[list_reg] = n + 1'b1;
                        end else begin
                            rd_addr = icht_pkg::line_of(list_reg, hd, n - 1'b1);
                            state_next = icht_pkg::ST_LAST;
                        end
                    end
                    icht_pkg::CMD_READ_LAST: begin
                        if (n == '0) begin
                            res_next.result_index   = snap_idx_reg[list_reg];
                            res_next.result_payload = snap_pay_reg[list_reg];
                            res_next.from_snapshot  = 1'b1;
                        end else begin
                            rd_addr = icht_pkg::line_of(list_reg, hd, n - 1'b1);
                            state_next = icht_pkg::ST_LAST;
                        end
                    end
                    icht_pkg::CMD_DROP_FRONT, icht_pkg::CMD_DROP_BACK: begin
                        if (count_reg[0] != '0) begin
                            cur_next = 1'b0;
                            cnt2 = count_reg[0];
                            h2 = head_reg[0];
                        end else begin
                            cur_next = 1'b1;
                            cnt2 = count_reg[1];
                            h2 = head_reg[1];
                        end
                        if (cnt2 != '0) begin
                            if (cmd_reg == icht_pkg::CMD_DROP_FRONT) begin
                                rd_addr = icht_pkg::line_of(cur_next, h2, '0);
                                state_next = icht_pkg::ST_FRONT;
                            end else begin
                                rd_addr = icht_pkg::line_of(cur_next, h2, cnt2 - 1'b1);
                                state_next = icht_pkg::ST_BACK;
                            end
                        end
                    end
                    icht_pkg::CMD_SET_SNAP: begin
                        if (key_reg < snap_idx_reg[list_reg]) begin
                            res_next.status = icht_pkg::ST_OLD_SNAP;
                        end else begin
                            snap_idx_next[list_reg] = key_reg;
                            snap_pay_next[list_reg] = pay_reg;
                        end
                    end
                    icht_pkg::CMD_FLOOR: begin
                        if (n == '0) begin
                            if (key_reg < snap_idx_reg[0]) begin
                                res_next.status = icht_pkg::ST_BELOW_SNAP;
                            end
                            res_next.result_index   = snap_idx_reg[0];
                            res_next.result_payload = snap_pay_reg[0];
                            res_next.from_snapshot  = 1'b1;
                        end else begin
                            pos_next = '0;
                            rd_addr = icht_pkg::line_of(list_reg, hd, '0);
                            state_next = icht_pkg::ST_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            icht_pkg::ST_LAST: begin
                state_next = icht_pkg::ST_DONE;
                if (cmd_reg == icht_pkg::CMD_APPEND) begin
                    if (rd_idx_reg >= key_reg) begin
                        res_next.status = icht_pkg::ST_ORDER;
                    end else if (n >= icht_pkg::CNT_W'(icht_pkg::DEPTH)) begin
                        res_next.status = icht_pkg::ST_FULL;
                    end else begin
                        wr_en = 1'b1;
                        wr_addr = icht_pkg::line_of(list_reg, hd, n);
                        count_next[list_reg] = n + 1'b1;
                    end
                end else begin
                    res_next.result_index   = rd_idx_reg;
                    res_next.result_payload = rd_pay_reg;
                end
            end
            icht_pkg::ST_FRONT: begin
                if (rd_idx_reg < key_reg) begin
                    h2 = icht_pkg::head_inc(head_reg[cur_reg]);
                    cnt2 = cnt - 1'b1;
                    head_next[cur_reg]  = h2;
                    count_next[cur_reg] = cnt2;
                    if (cnt2 != '0) begin
                        rd_addr = icht_pkg::line_of(cur_reg, h2, '0);
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    adv = 1'b1;
                end
                // advance to the learner list once the voter list is done
                if (adv) begin
                    if (!cur_reg && count_reg[1] != '0) begin
                        cur_next = 1'b1;
                        rd_addr = icht_pkg::line_of(1'b1, head_reg[1], '0);
                    end else begin
                        state_next = icht_pkg::ST_DONE;
                    end
                end
            end
            icht_pkg::ST_BACK: begin
                if (rd_idx_reg > key_reg) begin
                    cnt2 = cnt - 1'b1;
                    count_next[cur_reg] = cnt2;
                    if (cnt2 != '0) begin
                        rd_addr = icht_pkg::line_of(cur_reg, head_reg[cur_reg], cnt2 - 1'b1);
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    adv = 1'b1;
                end
                if (adv) begin
                    if (!cur_reg && count_reg[1] != '0) begin
                        cur_next = 1'b1;
                        rd_addr = icht_pkg::line_of(1'b1, head_reg[1], count_reg[1] - 1'b1);
                    end else begin
                        state_next = icht_pkg::ST_DONE;
                    end
                end
            end
            icht_pkg::ST_SCAN: begin
                if (rd_idx_reg <= key_reg) begin
                    best_idx_next = rd_idx_reg;
                    best_pay_next = rd_pay_reg;
                    p1 = pos_reg + 1'b1;
                    if (p1 < n) begin
                        pos_next = p1;
                        rd_addr = icht_pkg::line_of(list_reg, hd, p1);
                    end else begin
                        res_next.result_index   = rd_idx_reg;
                        res_next.result_payload = rd_pay_reg;
                        state_next = icht_pkg::ST_DONE;
                    end
                end else begin
                    // first entry already above the key: fall back to voter snapshot
                    if (pos_reg == '0) begin
                        res_next.result_index   = snap_idx_reg[0];
                        res_next.result_payload = snap_pay_reg[0];
                        res_next.from_snapshot  = 1'b1;
                    end else begin
                        res_next.result_index   = best_idx_reg;
                        res_next.result_payload = best_pay_reg;
                    end
                    state_next = icht_pkg::ST_DONE;
                end
            end
            icht_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = icht_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = icht_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg[0] <= icht_pkg::CNT_W'(icht_pkg::DEPTH)
        && count_reg[1] <= icht_pkg::CNT_W'(icht_pkg::DEPTH))
        else $error("list count above depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg[0] <= icht_pkg::PTR_W'(icht_pkg::DEPTH - 1)
        && head_reg[1] <= icht_pkg::PTR_W'(icht_pkg::DEPTH - 1))
        else $error("ring head out of range");

    a_write_only_append: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (cmd_reg == icht_pkg::CMD_APPEND)
        && (state_reg == icht_pkg::ST_EXEC || state_reg == icht_pkg::ST_LAST))
        else $error("store write outside append");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transfer taken while a command is in flight");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("pending result changed before its transfer");

endmodule
